FILE: src/saws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package saws_pkg;

  localparam int CoordW  = 12;
  localparam int TargetW = 10;
  localparam int StatusW = 3;
  localparam int RefW    = 32;
  localparam int OutLenW = 11;
  localparam int DataW   = 32;

  localparam logic [TargetW-1:0] TargetReset = 10'd9;
  localparam logic [1:0]         RegTarget   = 2'd0;

  typedef enum logic [StatusW-1:0] {
    ST_GREW     = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_TRAPPED  = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_RESTART  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INIT   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_MOVE  = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/self_avoiding_walk_step.sv
`timescale 1ns / 1ps
`default_nettype none
// a start passes through S_INIT, then S_EMIT; a move on an ended or finished walk goes
// straight to S_EMIT; any other move scans the path in S_SCAN (one stored cell read per
// cycle from the single path ram port, compared against all four head neighbours at once),
// then S_DECIDE and S_EMIT; one transaction at a time, next input taken once the result is registered
// reset: rst_n synchronous active low; path empty, walk ended, refusal count zero,
// target_growths 9; path ram contents are not cleared
module self_avoiding_walk_step
  import saws_pkg::*;
#(
  parameter int MAX_CELLS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_command,
  input  wire logic [1:0]            in_direction,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [StatusW-1:0]         out_status,
  output logic signed [CoordW-1:0]   out_head_x,
  output logic signed [CoordW-1:0]   out_head_y,
  output logic [OutLenW-1:0]         out_path_length,
  output logic [RefW-1:0]            out_refusal_total,

  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [1:0]            cfg_paddr,
  input  wire logic [DataW-1:0]      cfg_pwdata,
  output logic [DataW-1:0]           cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int TW = (CW > TargetW) ? CW : TargetW;
  localparam int RW = 2 * CoordW;

  state_t                state_r, state_nxt;
  status_t               status_r, status_nxt;
  logic [TargetW-1:0]    target_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [RefW-1:0]       ref_r, ref_nxt;
  logic                  ended_r, ended_nxt;
  logic [CoordW-1:0]     hx_r, hx_nxt, hy_r, hy_nxt;
  logic [1:0]            dir_r, dir_nxt;
  logic [3:0]            taken_r, taken_nxt;
  logic [CoordW-1:0]     nbx_r [4];
  logic [CoordW-1:0]     nby_r [4];
  logic [CoordW-1:0]     nbx_nxt [4];
  logic [CoordW-1:0]     nby_nxt [4];

  logic                  out_valid_r;
  logic [StatusW-1:0]    out_status_r;
  logic [CoordW-1:0]     out_hx_r, out_hy_r;
  logic [OutLenW-1:0]    out_len_r;
  logic [RefW-1:0]       out_ref_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [RW-1:0]         ram_wdata, ram_rdata;

  logic                  in_acc, cfg_wr;
  logic [CW-1:0]         cnt_inc;
  logic                  met_now, met_inc;
  logic [TW-1:0]         grow_now, grow_inc;

  saws_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_CELLS)
  ) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = DataW'(target_r);

  assign cnt_inc  = cnt_r + CW'(1);
  assign grow_now = TW'(cnt_r) - TW'(2);
  assign grow_inc = TW'(cnt_inc) - TW'(2);
  assign met_now  = (cnt_r >= CW'(MAX_CELLS)) || (grow_now >= TW'(target_r));
  assign met_inc  = (cnt_inc >= CW'(MAX_CELLS)) || (grow_inc >= TW'(target_r));

  assign ram_raddr = idx_r[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    ref_nxt    = ref_r;
    ended_nxt  = ended_r;
    hx_nxt     = hx_r;
    hy_nxt     = hy_r;
    dir_nxt    = dir_r;
    taken_nxt  = taken_r;
    nbx_nxt    = nbx_r;
    nby_nxt    = nby_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_START) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            state_nxt = S_INIT;
          end else if (ended_r || cnt_r < CW'(2)) begin
            status_nxt = ST_COMPLETE;
            state_nxt  = S_EMIT;
          end else if (met_now) begin
            ended_nxt  = 1'b1;
            status_nxt = ST_COMPLETE;
            state_nxt  = S_EMIT;
          end else begin
            dir_nxt    = in_direction;
            taken_nxt  = '0;
            idx_nxt    = '0;
            nbx_nxt[0] = hx_r + CoordW'(1);
            nby_nxt[0] = hy_r;
            nbx_nxt[1] = hx_r - CoordW'(1);
            nby_nxt[1] = hy_r;
            nbx_nxt[2] = hx_r;
            nby_nxt[2] = hy_r + CoordW'(1);
            nbx_nxt[3] = hx_r;
            nby_nxt[3] = hy_r - CoordW'(1);
            state_nxt  = S_SCAN;
          end
        end
      end
      S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(1);
        ram_wdata  = {CoordW'(1), CoordW'(0)};
        cnt_nxt    = CW'(2);
        ended_nxt  = 1'b0;
        hx_nxt     = CoordW'(1);
        hy_nxt     = '0;
        status_nxt = ST_RESTART;
        state_nxt  = S_EMIT;
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          for (int k = 0; k < 4; k++) begin
            if (ram_rdata == {nbx_r[k], nby_r[k]}) begin
              taken_nxt[k] = 1'b1;
            end
          end
        end
        if (idx_r < cnt_r) begin
          idx_nxt    = idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (&taken_r) begin
          ended_nxt  = 1'b1;
          status_nxt = ST_TRAPPED;
        end else if (taken_r[dir_r]) begin
          if (ref_r != '1) begin
            ref_nxt = ref_r + RefW'(1);
          end
          status_nxt = ST_REFUSED;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = {nbx_r[dir_r], nby_r[dir_r]};
          cnt_nxt   = cnt_inc;
          hx_nxt    = nbx_r[dir_r];
          hy_nxt    = nby_r[dir_r];
          if (met_inc) begin
            ended_nxt  = 1'b1;
            status_nxt = ST_COMPLETE;
          end else begin
            status_nxt = ST_GREW;
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_COMPLETE;
      target_r    <= TargetReset;
      cnt_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      ref_r       <= '0;
      ended_r     <= 1'b1;
      hx_r        <= '0;
      hy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      ref_r    <= ref_nxt;
      ended_r  <= ended_nxt;
      hx_r     <= hx_nxt;
      hy_r     <= hy_nxt;
      if (cfg_wr && cfg_paddr == RegTarget) begin
        target_r <= cfg_pwdata[TargetW-1:0];
      end
      if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dir_r   <= dir_nxt;
    taken_r <= taken_nxt;
    nbx_r   <= nbx_nxt;
    nby_r   <= nby_nxt;
    if (state_r == S_EMIT && (!out_valid_r || out_ready)) begin
      out_status_r <= status_r;
      out_hx_r     <= hx_r;
      out_hy_r     <= hy_r;
      out_len_r    <= OutLenW'(cnt_r);
      out_ref_r    <= ref_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_x        = out_hx_r;
  assign out_head_y        = out_hy_r;
  assign out_path_length   = out_len_r;
  assign out_refusal_total = out_ref_r;

endmodule
`default_nettype wire

FILE: src/saws_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module saws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
